// ===== src/dsm_pkg.sv =====
package dsm_pkg;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_SKIP = 4'b0001,
    PH_INT  = 4'b0010,
    PH_FRAC = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  // Character codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // Time scale factors
  localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
  localparam logic [15:0] MS_PER_MIN  = 16'd60000;
  localparam logic [9:0]  MS_PER_SEC  = 10'd1000;
  localparam logic [6:0]  FRAC_X100   = 7'd100;
  localparam logic [3:0]  FRAC_X10    = 4'd10;

  localparam int unsigned FIELDS = 3;

endpackage

// ===== src/duration_string_to_ms.sv =====
// Channel | Ports                                   | Direction
// --------+-----------------------------------------+----------
// in      | in_valid in_stall in_char_code in_last  | one character per word
// out     | out_valid out_stall out_milliseconds    | one word per text
//         | out_matched out_saturated               |
//
// One character is taken per cycle while in_stall is low, with no gap between
// texts. A text's word moves through the capture, multiply and sum/saturate
// stages. The three result stages each hold a word and move on their own, so
// characters keep flowing while a finished word waits on out_stall, until all
// three are full. rst_n (synchronous) clears the parser and all stage valids.
module duration_string_to_ms (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_milliseconds,
  output logic        out_matched,
  output logic        out_saturated
);

  // Parser state
  dsm_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] fld_r [dsm_pkg::FIELDS];
  logic [31:0] fld_nxt [dsm_pkg::FIELDS];
  logic [9:0]  fv_r, fv_nxt;
  logic [1:0]  fd_r, fd_nxt;
  logic        ovf_r, ovf_nxt;

  // Stage enables and valids
  logic v1_r, v2_r, out_valid_r;
  logic en1, en2, en3;
  logic acc;

  assign en3      = !out_valid_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;
  assign acc      = in_valid && en1;

  // Character classes
  logic       is_dig, is_sp;
  logic [3:0] dig;
  logic [1:0] idx;
  logic [35:0] acc_sum;

  always_comb begin
    is_dig  = in_char_code inside {[8'h30:8'h39]};
    is_sp   = in_char_code inside {[8'h09:8'h0D], 8'h20};
    dig     = in_char_code[3:0];
    idx     = cnt_r - 2'd1;
    acc_sum = {fld_r[idx], 3'b000} + {3'b000, fld_r[idx], 1'b0} + {32'd0, dig};
  end

  // Next parser state for one character
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    fld_nxt   = fld_r;
    fv_nxt    = fv_r;
    fd_nxt    = fd_r;
    ovf_nxt   = ovf_r;
    case (phase_r)
      dsm_pkg::PH_SKIP: begin
        if (is_sp) begin
          phase_nxt = dsm_pkg::PH_SKIP;
        end else if (is_dig && cnt_r < 2'd3) begin
          fld_nxt[cnt_r] = {28'd0, dig};
          cnt_nxt        = cnt_r + 2'd1;
          phase_nxt      = dsm_pkg::PH_INT;
        end else begin
          phase_nxt = dsm_pkg::PH_DONE;
        end
      end
      dsm_pkg::PH_INT: begin
        if (is_dig && cnt_r != 2'd0) begin
          if (acc_sum[35:32] != 4'd0) begin
            fld_nxt[idx] = 32'hFFFF_FFFF;
            ovf_nxt      = 1'b1;
          end else begin
            fld_nxt[idx] = acc_sum[31:0];
          end
        end else if (in_char_code == dsm_pkg::CH_COLON && cnt_r < 2'd3) begin
          phase_nxt = dsm_pkg::PH_SKIP;
        end else if (in_char_code == dsm_pkg::CH_DOT
                     || in_char_code == dsm_pkg::CH_COMMA) begin
          phase_nxt = dsm_pkg::PH_FRAC;
        end else begin
          phase_nxt = dsm_pkg::PH_DONE;
        end
      end
      dsm_pkg::PH_FRAC: begin
        if (is_dig) begin
          if (fd_r < 2'd3) begin
            fv_nxt = 10'({fv_r, 3'b000} + {fv_r, 1'b0} + {10'd0, dig});
            fd_nxt = fd_r + 2'd1;
          end
        end else begin
          phase_nxt = dsm_pkg::PH_DONE;
        end
      end
      default: phase_nxt = dsm_pkg::PH_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_last)) begin
      phase_r <= dsm_pkg::PH_SKIP;
      cnt_r   <= 2'd0;
      fv_r    <= 10'd0;
      fd_r    <= 2'd0;
      ovf_r   <= 1'b0;
      for (int i = 0; i < dsm_pkg::FIELDS; i++) fld_r[i] <= 32'd0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      fv_r    <= fv_nxt;
      fd_r    <= fd_nxt;
      ovf_r   <= ovf_nxt;
      fld_r   <= fld_nxt;
    end
  end

  // Stage 1: map fields to h/m/s and scale the fraction
  logic [31:0] h_r, m_r, s_r;
  logic [9:0]  frac_r;
  logic        mat1_r, ovf1_r;
  logic [31:0] h_c, m_c, s_c;
  logic [9:0]  frac_c;

  always_comb begin
    h_c = 32'd0;
    m_c = 32'd0;
    s_c = 32'd0;
    case (cnt_nxt)
      2'd1: s_c = fld_nxt[0];
      2'd2: begin
        m_c = fld_nxt[0];
        s_c = fld_nxt[1];
      end
      2'd3: begin
        h_c = fld_nxt[0];
        m_c = fld_nxt[1];
        s_c = fld_nxt[2];
      end
      default: ;
    endcase
    case (fd_nxt)
      2'd1:    frac_c = 10'(fv_nxt * dsm_pkg::FRAC_X100);
      2'd2:    frac_c = 10'(fv_nxt * dsm_pkg::FRAC_X10);
      2'd3:    frac_c = fv_nxt;
      default: frac_c = 10'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      h_r    <= h_c;
      m_r    <= m_c;
      s_r    <= s_c;
      frac_r <= frac_c;
      mat1_r <= cnt_nxt != 2'd0;
      ovf1_r <= ovf_nxt;
    end
  end

  // Stage 2: constant multiplies
  logic [53:0] ph_r;
  logic [47:0] pm_r;
  logic [41:0] ps_r;
  logic [9:0]  frac2_r;
  logic        mat2_r, ovf2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      ph_r    <= h_r * dsm_pkg::MS_PER_HOUR;
      pm_r    <= m_r * dsm_pkg::MS_PER_MIN;
      ps_r    <= s_r * dsm_pkg::MS_PER_SEC;
      frac2_r <= frac_r;
      mat2_r  <= mat1_r;
      ovf2_r  <= ovf1_r;
    end
  end

  // Stage 3: sum and saturate
  logic [54:0] total;
  logic        big;

  always_comb begin
    total = {1'b0, ph_r} + {7'd0, pm_r} + {13'd0, ps_r} + {45'd0, frac2_r};
    big   = total[54:32] != 23'd0;
  end

  logic [31:0] ms_r;
  logic        mat_r, sat_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      mat_r <= mat2_r;
      if (!mat2_r) begin
        ms_r  <= 32'd0;
        sat_r <= 1'b0;
      end else begin
        ms_r  <= big ? 32'hFFFF_FFFF : total[31:0];
        sat_r <= big || ovf2_r;
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= acc && in_last;
      if (en2) v2_r <= v1_r;
      if (en3) out_valid_r <= v2_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_milliseconds = ms_r;
  assign out_matched      = mat_r;
  assign out_saturated    = sat_r;

endmodule
